// File: sv/emaf_pkg.sv
// ---------------------------------------------------------------------------
// emaf_pkg
// Shared types and constants for the smoothing / moving-average filter.
// ---------------------------------------------------------------------------
package emaf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 64;

  localparam int HIST_AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + HIST_AW + 1;
  localparam int MAG_W    = SUM_W - 1;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam int Y_W      = SAMPLE_BITS + FRAC_W;
  localparam int DIFF_W   = Y_W + 1;
  localparam int PROD_W   = WEIGHT_W + 1 + DIFF_W;
  localparam int DSTEP_W  = $clog2(SAMPLE_BITS);

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(32768);
  localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(8);

  typedef enum logic {
    MODE_EMA = 1'b0,
    MODE_AVG = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [WEIGHT_W-1:0]  weight;
    logic [WIN_W-1:0]     window;
  } cfg_t;

  typedef struct packed {
    mode_t                          op;
    logic                           first;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic signed [SUM_W-1:0]        sum;
    logic [WIN_W-1:0]               win;
    logic [WIN_W-1:0]               reps;
    logic                           eob;
  } cmd_t;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic {
    F_IDLE,
    F_EXEC
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_DIV,
    B_SIGN,
    B_EMIT
  } bstate_t;

endpackage

// File: sv/emaf_ram.sv
// ---------------------------------------------------------------------------
// emaf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module emaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/emaf_cmd_q.sv
// ---------------------------------------------------------------------------
// emaf_cmd_q
// Short command queue between the front end and the arithmetic back end.
// ---------------------------------------------------------------------------
module emaf_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  emaf_pkg::cmd_t wr_cmd,
  output logic           q_full,
  input  logic           rd_en,
  output emaf_pkg::cmd_t rd_cmd,
  output logic           q_empty
);
  import emaf_pkg::*;

  cmd_t               ent_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r;
  logic [CMDQ_AW-1:0] rptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/emaf_front.sv
// ---------------------------------------------------------------------------
// emaf_front
// Accepts samples, tracks block state, keeps the sample history and running
// sum, and issues one command per sample that produces results.
// ---------------------------------------------------------------------------
module emaf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  emaf_pkg::cfg_t                      cfg,
  input  logic signed [emaf_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                in_end_of_block,
  input  logic                                push,
  output logic                                full,
  output logic                                cmd_push,
  output emaf_pkg::cmd_t                      cmd,
  input  logic                                cmd_full
);
  import emaf_pkg::*;

  fstate_t                       fstate_r, fstate_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          eob_r;
  logic                          started_r;
  mode_t                         mode_r;
  logic [WIN_W-1:0]              win_r;
  logic [HIST_AW-1:0]            hptr_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [WIN_W-1:0]              seen_r;

  logic                          first;
  logic [WIN_W-1:0]              cfg_win;
  mode_t                         mode_c;
  logic [WIN_W-1:0]              win_c;
  logic [HIST_AW-1:0]            hp_c;
  logic [HIST_AW-1:0]            hp_next;
  logic signed [SUM_W-1:0]       sum_c;
  logic [WIN_W-1:0]              seen_c;
  logic                          win_full;
  logic signed [SUM_W-1:0]       sum_new;
  logic [WIN_W-1:0]              seen_new;
  logic                          avg_ready;
  logic                          need_cmd;
  logic                          go;
  logic [HIST_AW:0]              old_wide;
  logic [HIST_AW-1:0]            old_addr;
  logic signed [SAMPLE_BITS-1:0] old_x;
  logic                          ram_we;

  // oldest sample of the window, wrapping around the history
  always_comb begin
    if ({1'b0, hptr_r} >= (HIST_AW+1)'(win_r)) begin
      old_wide = {1'b0, hptr_r} - (HIST_AW+1)'(win_r);
    end else begin
      old_wide = {1'b0, hptr_r} + (HIST_AW+1)'(MAX_WINDOW) - (HIST_AW+1)'(win_r);
    end
    old_addr = old_wide[HIST_AW-1:0];
  end

  emaf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hp_c),
    .wdata (x_r),
    .raddr (old_addr),
    .rdata (old_x)
  );

  always_comb begin
    first = !started_r;
    if (cfg.window == '0) begin
      cfg_win = WIN_W'(1);
    end else if (cfg.window > WIN_W'(MAX_WINDOW)) begin
      cfg_win = WIN_W'(MAX_WINDOW);
    end else begin
      cfg_win = cfg.window;
    end
    mode_c  = first ? cfg.mode : mode_r;
    win_c   = first ? cfg_win : win_r;
    hp_c    = first ? '0 : hptr_r;
    sum_c   = first ? '0 : sum_r;
    seen_c  = first ? '0 : seen_r;
    hp_next = (hp_c == HIST_AW'(MAX_WINDOW - 1)) ? '0 : hp_c + 1'b1;

    win_full = (seen_c >= win_c);
    if (win_full) begin
      sum_new  = sum_c - SUM_W'(old_x) + SUM_W'(x_r);
      seen_new = seen_c;
    end else begin
      sum_new  = sum_c + SUM_W'(x_r);
      seen_new = seen_c + 1'b1;
    end
    avg_ready = (seen_new >= win_c);
    need_cmd  = (mode_c == MODE_EMA) || avg_ready || eob_r;
  end

  // outputs
  always_comb begin
    full     = (fstate_r == F_EXEC);
    go       = (fstate_r == F_EXEC) && (!need_cmd || !cmd_full);
    cmd_push = go && need_cmd;
    ram_we   = go && (mode_c == MODE_AVG);

    cmd.op     = mode_c;
    cmd.first  = first;
    cmd.sample = x_r;
    cmd.sum    = sum_new;
    cmd.win    = win_c;
    cmd.eob    = eob_r;
    if (mode_c == MODE_EMA) begin
      cmd.reps = WIN_W'(1);
    end else if (avg_ready) begin
      cmd.reps = eob_r ? win_c : WIN_W'(1);
    end else begin
      // short block ends: one result per sample seen
      cmd.reps = seen_new;
    end
  end

  // next state
  always_comb begin
    fstate_nxt = fstate_r;
    unique case (fstate_r)
      F_IDLE: begin
        if (push) begin
          fstate_nxt = F_EXEC;
        end
      end
      F_EXEC: begin
        if (go) begin
          fstate_nxt = F_IDLE;
        end
      end
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fstate_r == F_IDLE && push) begin
      x_r   <= in_sample_in;
      eob_r <= in_end_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r  <= F_IDLE;
      started_r <= 1'b0;
      mode_r    <= MODE_EMA;
      win_r     <= WIN_W'(1);
      hptr_r    <= '0;
      sum_r     <= '0;
      seen_r    <= '0;
    end else begin
      fstate_r <= fstate_nxt;
      if (go) begin
        if (eob_r) begin
          started_r <= 1'b0;
          hptr_r    <= '0;
          sum_r     <= '0;
          seen_r    <= '0;
        end else begin
          started_r <= 1'b1;
          mode_r    <= mode_c;
          win_r     <= win_c;
          if (mode_c == MODE_AVG) begin
            hptr_r <= hp_next;
            sum_r  <= sum_new;
            seen_r <= seen_new;
          end else begin
            hptr_r <= hp_c;
            sum_r  <= sum_c;
            seen_r <= seen_c;
          end
        end
      end
    end
  end

endmodule

// File: sv/emaf_back.sv
// ---------------------------------------------------------------------------
// emaf_back
// Executes commands: exponential smoothing update through a registered
// multiply, or a bit-serial divide of the running sum by the window, then
// emits the result the requested number of times into the output register.
// ---------------------------------------------------------------------------
module emaf_back (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [emaf_pkg::WEIGHT_W-1:0]            weight,
  input  emaf_pkg::cmd_t                           head,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  logic                                     pop,
  output logic                                     empty,
  output logic signed [emaf_pkg::SAMPLE_BITS-1:0]  out_filtered,
  output logic                                     out_final_output
);
  import emaf_pkg::*;

  bstate_t                       bstate_r, bstate_nxt;
  logic signed [Y_W-1:0]         y_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic [SAMPLE_BITS-1:0]        res_r;
  logic [WIN_W-1:0]              cnt_r;
  logic                          eob_r;
  logic                          neg_r;
  logic [WIN_W-1:0]              rem_r;
  logic [SAMPLE_BITS-1:0]        quo_r;
  logic [WIN_W-1:0]              win_r;
  logic [DSTEP_W-1:0]            step_r;
  logic                          ovld_r;
  logic [SAMPLE_BITS-1:0]        odata_r;
  logic                          ofinal_r;

  logic [WEIGHT_W-1:0]           alpha;
  logic signed [Y_W-1:0]         x_q16;
  logic signed [SUM_W-1:0]       abs_sum;
  logic [MAG_W-1:0]              mag;
  logic [WIN_W:0]                trial;
  logic                          ge;
  logic [WIN_W-1:0]              rem_nxt;
  logic signed [PROD_W-1:0]      acc;
  logic signed [Y_W-1:0]         y_nxt;
  logic                          slot_free;
  logic                          load;

  assign alpha = (weight > ONE_Q16) ? ONE_Q16 : weight;
  assign x_q16 = {head.sample, {FRAC_W{1'b0}}};

  always_comb begin
    abs_sum = head.sum[SUM_W-1] ? -head.sum : head.sum;
    mag     = abs_sum[MAG_W-1:0];
  end

  // one restoring divide step per cycle
  always_comb begin
    trial   = {rem_r, quo_r[SAMPLE_BITS-1]};
    ge      = (trial >= {1'b0, win_r});
    rem_nxt = ge ? WIN_W'(trial - {1'b0, win_r}) : trial[WIN_W-1:0];
  end

  // floor of the scaled step is an arithmetic shift
  always_comb begin
    acc   = PROD_W'(y_r) + (prod_r >>> FRAC_W);
    y_nxt = acc[Y_W-1:0];
  end

  // outputs
  always_comb begin
    slot_free = !ovld_r || pop;
    q_pop     = (bstate_r == B_IDLE) && !q_empty;
    load      = (bstate_r == B_EMIT) && slot_free;
  end

  // next state
  always_comb begin
    bstate_nxt = bstate_r;
    unique case (bstate_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.op == MODE_AVG) begin
            bstate_nxt = B_DIV;
          end else if (head.first) begin
            bstate_nxt = B_EMIT;
          end else begin
            bstate_nxt = B_MUL;
          end
        end
      end
      B_MUL:  bstate_nxt = B_ACC;
      B_ACC:  bstate_nxt = B_EMIT;
      B_DIV: begin
        if (step_r == DSTEP_W'(SAMPLE_BITS - 1)) begin
          bstate_nxt = B_SIGN;
        end
      end
      B_SIGN: bstate_nxt = B_EMIT;
      B_EMIT: begin
        if (load && cnt_r == WIN_W'(1)) begin
          bstate_nxt = B_IDLE;
        end
      end
      default: bstate_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (bstate_r)
      B_IDLE: begin
        if (!q_empty) begin
          eob_r  <= head.eob;
          cnt_r  <= head.reps;
          win_r  <= head.win;
          neg_r  <= head.sum[SUM_W-1];
          rem_r  <= WIN_W'(mag[MAG_W-1:SAMPLE_BITS]);
          quo_r  <= mag[SAMPLE_BITS-1:0];
          step_r <= '0;
          diff_r <= {x_q16[Y_W-1], x_q16} - {y_r[Y_W-1], y_r};
          res_r  <= head.sample;
        end
      end
      B_MUL: begin
        prod_r <= $signed({1'b0, alpha}) * diff_r;
      end
      B_ACC: begin
        res_r <= y_nxt[Y_W-1:FRAC_W];
      end
      B_DIV: begin
        rem_r  <= rem_nxt;
        quo_r  <= {quo_r[SAMPLE_BITS-2:0], ge};
        step_r <= step_r + 1'b1;
      end
      B_SIGN: begin
        res_r <= neg_r ? -quo_r : quo_r;
      end
      B_EMIT: begin
        if (load) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
    if (load) begin
      odata_r  <= res_r;
      ofinal_r <= eob_r && (cnt_r == WIN_W'(1));
    end
  end

  // smoothed value and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r <= B_IDLE;
      y_r      <= '0;
      ovld_r   <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      if (bstate_r == B_IDLE && !q_empty && head.op == MODE_EMA && head.first) begin
        y_r <= x_q16;
      end else if (bstate_r == B_ACC) begin
        y_r <= y_nxt;
      end
      if (load) begin
        ovld_r <= 1'b1;
      end else if (pop) begin
        ovld_r <= 1'b0;
      end
    end
  end

  assign empty            = !ovld_r;
  assign out_filtered     = odata_r;
  assign out_final_output = ofinal_r;

endmodule

// File: sv/ema_or_moving_average_filter_core.sv
// ---------------------------------------------------------------------------
// ema_or_moving_average_filter_core
// Block audio filter: exponential smoothing or moving average per block.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter through push/full with in_sample_in and in_end_of_block;
//   a transfer happens when push is high and full is low. Results leave
//   through empty/pop: out_filtered and out_final_output hold the oldest
//   result while empty is low, and pop takes it.
//   Mode and window are captured on the first sample of a block; the
//   smoothing weight is used as written. Registers sit at byte addresses
//   0 (mode), 4 (weight), 8 (window) on the APB port; pready is tied high.
//   Front end: a sample is captured, then the history RAM read data comes
//   back and the running sum is updated; full is high until that is done,
//   so no new sample is taken before the last one is through. Back end:
//   smoothing sends a block's first sample straight out and otherwise uses
//   a registered multiply, then accumulate; an average runs a restoring
//   divide (one quotient bit per cycle) and a sign fix; each result is then
//   loaded into the output register once it is free.
//   A two-entry command queue lets the front end run ahead of the back end.
//   If pop stays low, the output register holds, the back end stalls, the
//   queue fills and full stays high; nothing is dropped.
//   Reset (synchronous, rst_n low) clears block state, queue and output.
// ---------------------------------------------------------------------------
module ema_or_moving_average_filter_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic signed [emaf_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                                     in_end_of_block,
  input  logic                                     push,
  output logic                                     full,
  output logic signed [emaf_pkg::SAMPLE_BITS-1:0]  out_filtered,
  output logic                                     out_final_output,
  output logic                                     empty,
  input  logic                                     pop,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [emaf_pkg::PADDR_W-1:0]             paddr,
  input  logic [emaf_pkg::PDATA_W-1:0]             pwdata,
  output logic [emaf_pkg::PDATA_W-1:0]             prdata,
  output logic                                     pready
);
  import emaf_pkg::*;

  mode_t               mode_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [WIN_W-1:0]    window_r;
  cfg_t                cfg;
  logic                wr_en;
  logic [1:0]          reg_idx;

  logic                cmd_push;
  cmd_t                cmd;
  logic                cmd_full;
  logic                cmd_pop;
  cmd_t                cmd_head;
  logic                cmd_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_EMA;
      weight_r <= WEIGHT_RESET;
      window_r <= WINDOW_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:   mode_r   <= mode_t'(pwdata[0]);
        REG_WEIGHT: weight_r <= pwdata[WEIGHT_W-1:0];
        REG_WINDOW: window_r <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = PDATA_W'(mode_r);
      REG_WEIGHT: prdata = PDATA_W'(weight_r);
      REG_WINDOW: prdata = PDATA_W'(window_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.mode   = mode_r;
  assign cfg.weight = weight_r;
  assign cfg.window = window_r;

  emaf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_sample_in    (in_sample_in),
    .in_end_of_block (in_end_of_block),
    .push            (push),
    .full            (full),
    .cmd_push        (cmd_push),
    .cmd             (cmd),
    .cmd_full        (cmd_full)
  );

  emaf_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_cmd  (cmd_head),
    .q_empty (cmd_empty)
  );

  emaf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .weight           (weight_r),
    .head             (cmd_head),
    .q_empty          (cmd_empty),
    .q_pop            (cmd_pop),
    .pop              (pop),
    .empty            (empty),
    .out_filtered     (out_filtered),
    .out_final_output (out_final_output)
  );

endmodule

// File: tb/ema_or_moving_average_filter_core_tb.sv
// ---------------------------------------------------------------------------
// ema_or_moving_average_filter_core_tb
// Self-checking bench for the block smoothing / moving-average filter.
// Samples go in through the push/full side, results are taken through
// empty/pop, and registers are set over the APB port between phases. A
// scoreboard keeps its own copy of the filter state, predicts every result
// and compares each popped result against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ema_or_moving_average_filter_core_tb;
  import emaf_pkg::*;

  localparam int RANDOM_ITEMS  = 140;
  localparam int SETTLE_CYCLES = SAMPLE_BITS + MAX_WINDOW + 16;
  localparam int HOLD_CYCLES   = 300;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // predicts filter outputs from accepted samples and holds them until popped
  class smoothing_average_model;
    typedef struct {
      sample_t value;
      logic    last;
    } result_t;

    result_t awaited[$];

    mode_t               reg_mode;
    logic [WEIGHT_W-1:0] reg_weight;
    logic [WIN_W-1:0]    reg_window;

    sample_t     history[MAX_WINDOW];
    int unsigned head;
    longint      window_total;
    int unsigned filled;
    longint      level;
    bit          in_block;
    mode_t       blk_mode;
    int unsigned blk_window;

    int unsigned mismatches;
    int unsigned samples;
    int unsigned outputs;
    int unsigned ema_blocks;
    int unsigned avg_blocks;

    function new();
      reg_mode     = MODE_EMA;
      reg_weight   = WEIGHT_RESET;
      reg_window   = WINDOW_RESET;
      head         = 0;
      window_total = 0;
      filled       = 0;
      level        = 0;
      in_block     = 0;
      blk_mode     = MODE_EMA;
      blk_window   = 1;
      mismatches   = 0;
      samples      = 0;
      outputs      = 0;
      ema_blocks   = 0;
      avg_blocks   = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_MODE:   reg_mode = mode_t'(value[0]);
        REG_WEIGHT: reg_weight = value[WEIGHT_W-1:0];
        REG_WINDOW: reg_window = value[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned effective_window();
      if (reg_window == 0) return 1;
      if (reg_window > MAX_WINDOW) return MAX_WINDOW;
      return reg_window;
    endfunction

    function void add_result(longint v, logic last);
      result_t r;
      r.value = sample_t'(v);
      r.last  = last;
      awaited.push_back(r);
    endfunction

    function void take_sample(sample_t x, logic eob);
      longint      a;
      longint      avg;
      int unsigned p;
      int unsigned reps;
      samples++;
      if (!in_block) begin
        blk_mode     = reg_mode;
        blk_window   = effective_window();
        window_total = 0;
        filled       = 0;
        head         = 0;
        if (blk_mode == MODE_EMA) ema_blocks++;
        else avg_blocks++;
      end
      if (blk_mode == MODE_EMA) begin
        if (!in_block) begin
          level = longint'(x) * 65536;
        end else begin
          // weight above one saturates to one
          a = (reg_weight > ONE_Q16) ? 65536 : longint'(reg_weight);
          level += (a * (longint'(x) * 65536 - level)) >>> FRAC_W;
        end
        add_result(level >>> FRAC_W, eob);
      end else begin
        p = head % MAX_WINDOW;
        if (filled >= blk_window)
          window_total -= history[(p + MAX_WINDOW - blk_window) % MAX_WINDOW];
        else
          filled++;
        window_total += x;
        history[p] = x;
        head = (p + 1) % MAX_WINDOW;
        if (filled >= blk_window) begin
          avg  = window_total / longint'(blk_window);
          reps = eob ? blk_window : 1;
          for (int unsigned i = 0; i < reps; i++)
            add_result(avg, eob && (i + 1 == reps));
        end else if (eob) begin
          // short block: one result per sample, sum still divided by the window
          avg = window_total / longint'(blk_window);
          for (int unsigned i = 0; i < filled; i++)
            add_result(avg, i + 1 == filled);
        end
      end
      if (eob) begin
        in_block     = 0;
        window_total = 0;
        filled       = 0;
        head         = 0;
      end else begin
        in_block = 1;
      end
    endfunction

    function void match_output(sample_t value, logic last);
      result_t want;
      outputs++;
      if (awaited.size() == 0) begin
        $error("unexpected result: filtered %0d final_output %0b", value, last);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $error("filtered: expected %0d, actual %0d", want.value, value);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("final_output: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  sample_t             in_sample_in;
  logic                in_end_of_block;
  logic                push;
  logic                full;
  sample_t             out_filtered;
  logic                out_final_output;
  logic                empty;
  logic                pop;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  smoothing_average_model model = new();

  bit quiet;
  int rx_hold_left;
  int rx_stall;

  ema_or_moving_average_filter_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample_in     (in_sample_in),
    .in_end_of_block  (in_end_of_block),
    .push             (push),
    .full             (full),
    .out_filtered     (out_filtered),
    .out_final_output (out_final_output),
    .empty            (empty),
    .pop              (pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2: return sample_t'($urandom_range(0, 6)) - sample_t'(3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
    if (r < 8) return $urandom_range(1, 4);
    if (r < 11) return $urandom_range(5, 12);
    return $urandom_range(13, 63);
  endfunction

  // averaging: mostly blocks that get past the fill-up, some short ones; smoothing: 1 to 8 samples
  function automatic int block_length(int unsigned w, bit averaging);
    int r;
    r = $urandom_range(0, 9);
    if (!averaging) return $urandom_range(1, 8);
    if (r < 7) return w + $urandom_range(0, 5);
    if (r < 9) return (w > 1) ? $urandom_range(1, w - 1) : 1;
    return $urandom_range(1, 2);
  endfunction

  // result side: pop stays high until a transfer, then a random stall; rx_hold_left holds it low first
  initial begin
    pop          = 1'b0;
    rx_hold_left = 0;
    rx_stall     = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        model.match_output(out_filtered, out_final_output);
        rx_stall = pick_gap();
      end
    end
  end

  task automatic send(input sample_t s, input logic eob);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push            <= 1'b1;
    in_sample_in    <= s;
    in_end_of_block <= eob;
    @(posedge clk);
    while (full) @(posedge clk);
    model.take_sample(s, eob);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending, wait for every predicted result, then let the back end settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (model.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_items;
    int phase_no;
    int blocks;
    int len;
    int unsigned w;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_sample_in    = '0;
    in_end_of_block = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    quiet           = 1'b0;
    random_items    = 0;
    phase_no        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smoothing with sample extremes, first sample passes through
    write_reg(REG_MODE, PDATA_W'(MODE_EMA));
    write_reg(REG_WEIGHT, 32768);
    write_reg(REG_WINDOW, 8);
    send(sample_t'(32767), 1'b0);
    send(sample_t'(-32768), 1'b0);
    send(sample_t'(-1), 1'b0);
    send(sample_t'(0), 1'b0);
    send(sample_t'(1), 1'b1);
    // weight above one acts as one
    drain();
    write_reg(REG_WEIGHT, 131071);
    send(sample_t'(100), 1'b0);
    send(sample_t'(-32768), 1'b1);
    // zero weight holds the first sample
    drain();
    write_reg(REG_WEIGHT, 0);
    send(sample_t'(-32768), 1'b0);
    send(sample_t'(32767), 1'b1);
    // averaging: short block, then a full one with the tail repeated
    drain();
    write_reg(REG_MODE, PDATA_W'(MODE_AVG));
    write_reg(REG_WINDOW, 4);
    send(sample_t'(-32768), 1'b0);
    send(sample_t'(-32768), 1'b0);
    send(sample_t'(32767), 1'b1);
    repeat (4) send(sample_t'(32767), 1'b0);
    send(sample_t'(32767), 1'b1);
    // window zero acts as one, window past the maximum is clamped
    drain();
    write_reg(REG_WINDOW, 0);
    send(sample_t'(-5), 1'b0);
    send(sample_t'(7), 1'b1);
    drain();
    write_reg(REG_WINDOW, 127);
    send(sample_t'(-3), 1'b1);
    // mode and window stay latched while a block is open
    drain();
    write_reg(REG_WINDOW, 2);
    send(sample_t'(10), 1'b0);
    send(sample_t'(20), 1'b0);
    drain();
    write_reg(REG_MODE, PDATA_W'(MODE_EMA));
    write_reg(REG_WINDOW, 3);
    send(sample_t'(30), 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 2) != 0) write_reg(REG_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) write_reg(REG_WEIGHT, pick_weight());
      if ($urandom_range(0, 2) != 0) write_reg(REG_WINDOW, pick_window());
      quiet = ($urandom_range(0, 4) == 0);
      w = model.effective_window();
      if (phase_no == 2) begin
        // receiver holds off while samples keep coming, so the input backs up
        write_reg(REG_MODE, PDATA_W'(MODE_EMA));
        quiet        = 1'b1;
        rx_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 16; i++) send(pick_sample(), i == 15);
        random_items += 16;
      end else begin
        blocks = $urandom_range(1, 4);
        for (int b = 0; b < blocks; b++) begin
          len = block_length(w, model.reg_mode == MODE_AVG);
          for (int i = 0; i < len; i++) send(pick_sample(), i == len - 1);
          random_items += len;
        end
        // leave a block open now and then so the next phase sees the latch
        if (phase_no != 1 && $urandom_range(0, 3) == 0) begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) send(pick_sample(), 1'b0);
          random_items += len;
        end
      end
      phase_no++;
    end

    quiet = 1'b0;
    drain();
    $display("covered %0d samples in %0d smoothing and %0d averaging blocks",
             model.samples, model.ema_blocks, model.avg_blocks);
    $display("checked %0d results over %0d phases, %0d mismatches",
             model.outputs, phase_no, model.mismatches);
    if (model.mismatches == 0 && model.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", model.awaited.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
